// ===== rtl/scp_pkg.sv =====
// scp_pkg: shared types, codes and helper functions of the serial CAN command parser.
// Used by every module of the block and by its checker. No dependencies.
`default_nettype none

package scp_pkg;

    typedef enum logic [3:0] {
        CMD_UNKNOWN   = 4'd0,
        CMD_OPEN      = 4'd1,
        CMD_CLOSE     = 4'd2,
        CMD_SETBAUD   = 4'd3,
        CMD_TX        = 4'd4,
        CMD_RTR       = 4'd5,
        CMD_FLAGS     = 4'd6,
        CMD_STATUS    = 4'd7,
        CMD_HELP      = 4'd8,
        CMD_MODE_UART = 4'd9,
        CMD_MODE_CAN  = 4'd10
    } cmd_t;

    typedef enum logic [11:0] {
        PH_START   = 12'b0000_0000_0001,
        PH_DONE    = 12'b0000_0000_0010,
        PH_S_DIGIT = 12'b0000_0000_0100,
        PH_ID      = 12'b0000_0000_1000,
        PH_DLC     = 12'b0000_0001_0000,
        PH_DATA    = 12'b0000_0010_0000,
        PH_MODE    = 12'b0000_0100_0000,
        PH_MODE_SP = 12'b0000_1000_0000,
        PH_CAN     = 12'b0001_0000_0000,
        PH_UART    = 12'b0010_0000_0000,
        PH_UART_SP = 12'b0100_0000_0000,
        PH_DEC     = 12'b1000_0000_0000
    } phase_t;

    localparam logic [31:0] DEFAULT_UART = 32'd115200;
    localparam logic [3:0]  DEFAULT_RATE = 4'd6;
    localparam logic [5:0]  POS_MAX      = 6'd63;
    localparam logic [5:0]  STD_ID_DIGITS = 6'd3;
    localparam logic [5:0]  EXT_ID_DIGITS = 6'd8;

    // flag bits
    localparam int FLAG_EXT    = 0;
    localparam int FLAG_REMOTE = 1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } item_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] frame_id;
        logic [3:0]  length_code;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  bitrate_index;
        logic [31:0] uart_rate;
        logic [63:0] payload;
    } result_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] mode_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = "m";
            2'd1:    r = "o";
            2'd2:    r = "d";
            default: r = "e";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] can_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = "c";
            2'd1:    r = "a";
            2'd2:    r = "n";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] uart_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = "u";
            2'd1:    r = "a";
            2'd2:    r = "r";
            default: r = "t";
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scp_in_stage.sv =====
// scp_in_stage: input register of the parser; holds one item until the core takes it.
// Depends on scp_pkg.
`default_nettype none

module scp_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          char_valid,
    output logic               char_stall,
    input  wire scp_pkg::item_t item_in,
    input  wire logic          take,
    output logic               stage_valid,
    output scp_pkg::item_t     stage_item
);
    import scp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign char_stall  = valid_reg && !take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            item_reg <= item_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scp_core.sv =====
// scp_core: parse state registers and the per-item next-state and result logic.
// Depends on scp_pkg.
`default_nettype none

module scp_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           stage_valid,
    input  wire scp_pkg::item_t stage_item,
    input  wire logic           out_free,
    output logic                take,
    output logic                res_load,
    output scp_pkg::result_t    res
);
    import scp_pkg::*;

    logic [5:0]  pos_reg,   pos_next;
    phase_t      phase_reg, phase_next;
    cmd_t        cls_reg,   cls_next;
    logic [31:0] id_reg,    id_next;
    logic [3:0]  len_reg,   len_next;
    logic [63:0] data_reg,  data_next;
    logic [31:0] dec_reg,   dec_next;
    logic [3:0]  rate_reg,  rate_next;
    logic [1:0]  flags_reg, flags_next;

    logic [7:0]  c;
    logic [4:0]  hx;
    logic [5:0]  pos_inc;
    logic [5:0]  data_sh;
    logic        do_fail;
    logic        is_frame;

    assign take     = stage_valid && (!stage_item.is_end || out_free);
    assign res_load = stage_valid && stage_item.is_end && out_free;
    assign c        = stage_item.char_code;

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        cls_next   = cls_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        data_next  = data_reg;
        dec_next   = dec_reg;
        rate_next  = rate_reg;
        flags_next = flags_reg;
        do_fail    = 1'b0;
        hx         = hex_decode(c);
        pos_inc    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 6'd1;
        data_sh    = {pos_reg[3:1], ~pos_reg[0], 2'b00};

        if (stage_item.is_end || c == 8'h00)
        begin
            // line end
            case (phase_reg)
                PH_DONE:
                begin
                end
                PH_S_DIGIT:
                begin
                    cls_next   = CMD_STATUS;
                    phase_next = PH_DONE;
                end
                PH_UART_SP, PH_DEC:
                begin
                    cls_next   = CMD_MODE_UART;
                    phase_next = PH_DONE;
                end
                default:   do_fail = 1'b1;
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    pos_next = 6'd0;
                    if (c == "o" || c == "O")
                    begin
                        cls_next = CMD_OPEN;   phase_next = PH_DONE;
                    end
                    else if (c == "c" || c == "C")
                    begin
                        cls_next = CMD_CLOSE;  phase_next = PH_DONE;
                    end
                    else if (c == "s" || c == "S")
                    begin
                        phase_next = PH_S_DIGIT;
                    end
                    else if (c == "i" || c == "I")
                    begin
                        cls_next = CMD_STATUS; phase_next = PH_DONE;
                    end
                    else if (c == "f" || c == "F")
                    begin
                        cls_next = CMD_FLAGS;  phase_next = PH_DONE;
                    end
                    else if (c == "h" || c == "H" || c == "?")
                    begin
                        cls_next = CMD_HELP;   phase_next = PH_DONE;
                    end
                    else if (c == "t")
                    begin
                        flags_next = 2'b00;    phase_next = PH_ID;
                    end
                    else if (c == "T")
                    begin
                        flags_next = 2'b00;
                        flags_next[FLAG_EXT] = 1'b1;
                        phase_next = PH_ID;
                    end
                    else if (c == "r" || c == "R")
                    begin
                        flags_next = 2'b00;
                        flags_next[FLAG_REMOTE] = 1'b1;
                        phase_next = PH_ID;
                    end
                    else if (c == "m")
                    begin
                        pos_next = 6'd1;       phase_next = PH_MODE;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_S_DIGIT:
                begin
                    phase_next = PH_DONE;
                    if (c >= "4" && c <= "8")
                    begin
                        rate_next = c[3:0];
                        cls_next  = CMD_SETBAUD;
                    end
                    else
                    begin
                        cls_next = CMD_STATUS;
                    end
                end
                PH_ID:
                begin
                    if (!hx[4])
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        id_next = {id_reg[27:0], hx[3:0]};
                        if (pos_inc >= (flags_reg[FLAG_EXT] ? EXT_ID_DIGITS : STD_ID_DIGITS))
                        begin
                            pos_next   = 6'd0;
                            phase_next = PH_DLC;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                end
                PH_DLC:
                begin
                    if (c < "0" || c > "8")
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        len_next = c[3:0];
                        pos_next = 6'd0;
                        if (flags_reg[FLAG_REMOTE])
                        begin
                            cls_next = CMD_RTR; phase_next = PH_DONE;
                        end
                        else if (c[3:0] == 4'd0)
                        begin
                            cls_next = CMD_TX;  phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (!hx[4])
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        data_next = data_reg | ({60'd0, hx[3:0]} << data_sh);
                        pos_next  = pos_inc;
                        if (pos_inc >= {1'b0, len_reg, 1'b0})
                        begin
                            cls_next = CMD_TX; phase_next = PH_DONE;
                        end
                    end
                end
                PH_MODE:
                begin
                    if (pos_reg < 6'd4 && c == mode_char(pos_reg[1:0]))
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= 6'd4)
                        begin
                            phase_next = PH_MODE_SP;
                        end
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_MODE_SP:
                begin
                    if (c == " ")
                    begin
                    end
                    else if (c == "c")
                    begin
                        pos_next = 6'd1; phase_next = PH_CAN;
                    end
                    else if (c == "u")
                    begin
                        pos_next = 6'd1; phase_next = PH_UART;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_CAN:
                begin
                    if (pos_reg < 6'd3 && c == can_char(pos_reg[1:0]))
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= 6'd3)
                        begin
                            cls_next = CMD_MODE_CAN; phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_UART:
                begin
                    if (pos_reg < 6'd4 && c == uart_char(pos_reg[1:0]))
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= 6'd4)
                        begin
                            phase_next = PH_UART_SP;
                        end
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_UART_SP, PH_DEC:
                begin
                    if (c >= "0" && c <= "9")
                    begin
                        dec_next   = (dec_reg << 3) + (dec_reg << 1) + {28'd0, c[3:0]};
                        phase_next = PH_DEC;
                    end
                    else if (c == " " && phase_reg == PH_UART_SP)
                    begin
                    end
                    else
                    begin
                        cls_next = CMD_MODE_UART; phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_fail)
        begin
            // a data byte with only its high digit is dropped
            if (phase_reg == PH_DATA && pos_reg[0])
            begin
                data_next = data_reg & ~(64'hFF << {pos_reg[3:1], 3'b000});
            end
            cls_next   = CMD_UNKNOWN;
            phase_next = PH_DONE;
        end
    end

    assign is_frame = (cls_next == CMD_TX) || (cls_next == CMD_RTR);

    always_comb
    begin
        res.command       = cls_next;
        res.frame_id      = is_frame ? id_reg : 32'd0;
        res.length_code   = is_frame ? len_reg : 4'd0;
        res.is_extended   = (cls_next == CMD_TX) && flags_reg[FLAG_EXT];
        res.is_remote     = (cls_next == CMD_RTR);
        res.bitrate_index = rate_reg;
        res.uart_rate     = (cls_next == CMD_MODE_UART && dec_reg != 32'd0)
                            ? dec_reg : DEFAULT_UART;
        res.payload       = data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 6'd0;
            phase_reg <= PH_START;
            cls_reg   <= CMD_UNKNOWN;
            id_reg    <= 32'd0;
            len_reg   <= 4'd0;
            data_reg  <= 64'd0;
            dec_reg   <= 32'd0;
            rate_reg  <= DEFAULT_RATE;
            flags_reg <= 2'b00;
        end
        else if (take && stage_item.is_end)
        begin
            pos_reg   <= 6'd0;
            phase_reg <= PH_START;
            cls_reg   <= CMD_UNKNOWN;
            id_reg    <= 32'd0;
            len_reg   <= 4'd0;
            data_reg  <= 64'd0;
            dec_reg   <= 32'd0;
            rate_reg  <= DEFAULT_RATE;
            flags_reg <= 2'b00;
        end
        else if (take && phase_reg != PH_DONE)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            cls_reg   <= cls_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            data_reg  <= data_next;
            dec_reg   <= dec_next;
            rate_reg  <= rate_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scp_out_stage.sv =====
// scp_out_stage: result register; holds a finished result until the receiver takes it.
// Depends on scp_pkg.
`default_nettype none

module scp_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_load,
    input  wire scp_pkg::result_t res_in,
    output logic                  out_free,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output scp_pkg::result_t      res_out
);
    import scp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign res_out      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/serial_can_command_parser.sv =====
// serial_can_command_parser: top level of the serial CAN command line parser.
// Depends on scp_pkg, scp_in_stage, scp_core, scp_out_stage.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------------
//   char     | char_valid / char_stall     | char_code, is_end
//   result   | result_valid / result_stall | command, frame_id, length_code, is_extended,
//            |                             | is_remote, bitrate_index, uart_rate, payload
//
// One item per cycle while char_stall is low: input register, parse logic, result register.
// An end item goes from the input register through the parse logic into the result register.
// Reset puts the parser at the start of a line with both registers empty.
// A stalled result blocks the next end item and all behind it; earlier characters flow.
`default_nettype none

module serial_can_command_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        is_end,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [3:0]       command,
    output logic [31:0]      frame_id,
    output logic [3:0]       length_code,
    output logic             is_extended,
    output logic             is_remote,
    output logic [3:0]       bitrate_index,
    output logic [31:0]      uart_rate,
    output logic [63:0]      payload
);
    import scp_pkg::*;

    item_t   item_in;
    item_t   stage_item;
    logic    stage_valid;
    logic    take;
    logic    res_load;
    logic    out_free;
    result_t res_core;
    result_t res_out;

    assign item_in.char_code = char_code;
    assign item_in.is_end    = is_end;

    scp_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .item_in     (item_in),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    scp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .out_free    (out_free),
        .take        (take),
        .res_load    (res_load),
        .res         (res_core)
    );

    scp_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_load     (res_load),
        .res_in       (res_core),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .res_out      (res_out)
    );

    assign command       = res_out.command;
    assign frame_id      = res_out.frame_id;
    assign length_code   = res_out.length_code;
    assign is_extended   = res_out.is_extended;
    assign is_remote     = res_out.is_remote;
    assign bitrate_index = res_out.bitrate_index;
    assign uart_rate     = res_out.uart_rate;
    assign payload       = res_out.payload;

endmodule

`default_nettype wire

// ===== rtl/scp_checker.sv =====
// scp_checker: port-level assertions for serial_can_command_parser, bound to the top level.
// Depends on scp_pkg and serial_can_command_parser.
`default_nettype none

module scp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        char_valid,
    input wire logic        char_stall,
    input wire logic [7:0]  char_code,
    input wire logic        is_end,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [3:0]  command,
    input wire logic [31:0] frame_id,
    input wire logic [3:0]  length_code,
    input wire logic        is_extended,
    input wire logic        is_remote,
    input wire logic [3:0]  bitrate_index,
    input wire logic [31:0] uart_rate,
    input wire logic [63:0] payload
);
    import scp_pkg::*;

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_code) && $stable(is_end))
        else $error("stalled input item changed");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result item dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(command) && $stable(frame_id)
            && $stable(payload) && $stable(uart_rate))
        else $error("stalled result item changed");

    a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && command != CMD_TX && command != CMD_RTR
            |-> frame_id == 32'd0 && length_code == 4'd0 && !is_extended && !is_remote)
        else $error("frame fields set on a non-frame command");

    a_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (command == CMD_MODE_UART || uart_rate == DEFAULT_UART)
            && (command == CMD_SETBAUD || bitrate_index == DEFAULT_RATE)
            && (is_remote == (command == CMD_RTR)))
        else $error("default fields wrong for command");

endmodule

bind serial_can_command_parser scp_checker u_scp_checker (.*);

`default_nettype wire
